### design/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared assertion wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Word types, field widths, controller states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        KIND_GET = 1'b0,
        KIND_PUT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } t_resp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_RESOLVE,
        ST_UPDATE,
        ST_UPDATE_END,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic resolve;
        logic upd_rd;
        logic reply;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic need_update;
    } t_status;

endpackage

`default_nettype wire

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage: present a get or put word on i_item and raise start while busy is
// low; the word is taken at that clock edge and busy stays high until the
// result goes out. Each result word is shown on o_result for exactly one
// cycle with o_strobe high; the receiver cannot stall it. The capacity
// register is written through i_cfg_we / i_cfg_data, by the user only while
// the block is idle; the block itself does not enforce this.
// Timing: each operation sweeps the entries one per cycle through stores
// with a registered read. A get miss runs only the tag scan; a hit or a
// put also runs a rank update sweep. A new word is accepted in the cycle
// the strobe is shown, not while an operation is in progress.
// Reset: i_rst_n (synchronous, active low) empties the cache, clears every
// valid bit and the occupancy count, and sets the capacity to 16. No
// clearing pass is needed; the contents of entries never written are unused.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire lkv_pkg::t_req             i_item,
    input  wire logic                      i_cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0] i_cfg_data,
    output logic                           o_strobe,
    output lkv_pkg::t_resp                 o_result
);

    lkv_pkg::t_cmd    cmd;
    lkv_pkg::t_status status;

    lkv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lkv_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result),
        .o_strobe   (o_strobe)
    );

endmodule

`default_nettype wire

### design/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences the tag scan, the resolve step, the rank update sweep and the reply.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lkv_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire lkv_pkg::t_status i_status,
    output lkv_pkg::t_cmd        o_cmd,
    output logic                 o_busy
);

    lkv_pkg::t_state r_state;
    lkv_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (i_status.idx_last) begin
                    n_state = lkv_pkg::ST_SCAN_END;
                end
            end
            lkv_pkg::ST_SCAN_END: begin
                n_state = lkv_pkg::ST_RESOLVE;
            end
            lkv_pkg::ST_RESOLVE: begin
                n_state = i_status.need_update ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_REPLY;
            end
            lkv_pkg::ST_UPDATE: begin
                if (i_status.idx_last) begin
                    n_state = lkv_pkg::ST_UPDATE_END;
                end
            end
            lkv_pkg::ST_UPDATE_END: begin
                n_state = lkv_pkg::ST_REPLY;
            end
            lkv_pkg::ST_REPLY: begin
                n_state = lkv_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            lkv_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = start;
            end
            lkv_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            lkv_pkg::ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
            end
            lkv_pkg::ST_UPDATE: begin
                o_cmd.upd_rd = 1'b1;
            end
            lkv_pkg::ST_REPLY: begin
                o_cmd.reply = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The scan may only end once the last entry's read has been issued.
    `LKV_ASSERT_NOW(a_scan_end_after_last, r_state == lkv_pkg::ST_SCAN_END, $past(i_status.idx_last), "scan ended early")

endmodule

`default_nettype wire

### design/lkv_dpath.sv
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key, value and rank stores, scan accumulators, replacement choice, results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_value_cache_defines.svh"

module lkv_dpath #(
    parameter int ENTRIES = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lkv_pkg::t_req                i_item,
    input  wire logic                         i_cfg_we,
    input  wire logic [lkv_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire lkv_pkg::t_cmd                i_cmd,
    output lkv_pkg::t_status                  o_status,
    output lkv_pkg::t_resp                    o_result,
    output logic                              o_strobe
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

    // Storage: keys and values written only for the chosen slot, ranks during the sweep; read one entry per cycle.
    logic [lkv_pkg::KEY_W-1:0]   r_key_mem  [ENTRIES];
    logic [lkv_pkg::VALUE_W-1:0] r_val_mem  [ENTRIES];
    logic [RANK_W-1:0]           r_rank_mem [ENTRIES];

    logic [lkv_pkg::KEY_W-1:0]   r_rd_key;
    logic [lkv_pkg::VALUE_W-1:0] r_rd_val;
    logic [RANK_W-1:0]           r_rd_rank;

    logic [lkv_pkg::CAP_W-1:0]   r_cap;
    lkv_pkg::t_req               r_in;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_pipe_vld;
    logic                        r_pipe_upd;
    logic [IDX_W-1:0]            r_pipe_idx;
    logic [ENTRIES-1:0]          r_valid;
    logic [CNT_W-1:0]            r_count;

    logic                        r_hit;
    logic [IDX_W-1:0]            r_hit_idx;
    logic [RANK_W-1:0]           r_hit_rank;
    logic [lkv_pkg::VALUE_W-1:0] r_hit_val;
    logic                        r_have_free;
    logic [IDX_W-1:0]            r_free_idx;
    logic                        r_have_old;
    logic [IDX_W-1:0]            r_old_idx;
    logic [RANK_W-1:0]           r_old_rank;
    logic [lkv_pkg::KEY_W-1:0]   r_old_key;

    logic [IDX_W-1:0]            r_slot;
    logic [RANK_W-1:0]           r_lim_rank;
    logic                        r_age_all;

    lkv_pkg::t_resp              r_res;
    logic                        r_strobe;

    logic                        is_put;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            eff_cap;
    logic                        sel_fill;
    logic                        sel_evict;
    logic [IDX_W-1:0]            slot_sel;
    logic                        idx_last;
    logic                        rd_any;
    logic                        pipe_valid_entry;
    logic                        rank_we;
    logic [RANK_W-1:0]           rank_wdata;

    assign is_put   = (r_in.kind == lkv_pkg::KIND_PUT);
    assign idx_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign rd_any   = i_cmd.scan_rd | i_cmd.upd_rd;
    assign pipe_valid_entry = r_valid[r_pipe_idx];

    assign o_status.idx_last    = idx_last;
    assign o_status.need_update = r_hit | is_put;
    assign o_result = r_res;
    assign o_strobe = r_strobe;

    // Capacity of zero acts as one; anything above the table size saturates.
    always_comb begin
        cap_ext = CMP_W'(r_cap);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    always_comb begin
        sel_fill  = !r_hit && is_put && (CMP_W'(r_count) < eff_cap);
        sel_evict = !r_hit && is_put && !(CMP_W'(r_count) < eff_cap);
        if (r_hit) begin
            slot_sel = r_hit_idx;
        end else if (sel_fill) begin
            slot_sel = r_free_idx;
        end else begin
            slot_sel = r_old_idx;
        end
    end

    // Rank sweep: the touched slot becomes rank zero; younger valid entries age, or all valid entries on a fill.
    always_comb begin
        rank_we    = 1'b0;
        rank_wdata = '0;
        if (r_pipe_vld && r_pipe_upd) begin
            if (r_pipe_idx == r_slot) begin
                rank_we = 1'b1;
            end else if (pipe_valid_entry && (r_age_all || (r_rd_rank < r_lim_rank))) begin
                rank_we    = 1'b1;
                rank_wdata = r_rd_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && is_put && !r_hit) begin
            r_key_mem[slot_sel] <= r_in.key;
        end
        if (i_cmd.scan_rd) begin
            r_rd_key <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && is_put) begin
            r_val_mem[slot_sel] <= r_in.value;
        end
        if (i_cmd.scan_rd) begin
            r_rd_val <= r_val_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[r_pipe_idx] <= rank_wdata;
        end
        if (rd_any) begin
            r_rd_rank <= r_rank_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.resolve) begin
            r_slot     <= slot_sel;
            r_age_all  <= sel_fill;
            r_lim_rank <= r_hit ? r_hit_rank : r_old_rank;
            r_res.found       <= r_hit;
            r_res.read_value  <= (r_hit && !is_put) ? r_hit_val : '0;
            r_res.evicted     <= sel_evict;
            r_res.evicted_key <= sel_evict ? r_old_key : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lkv_pkg::CAP_RESET;
            r_idx       <= '0;
            r_pipe_vld  <= 1'b0;
            r_pipe_upd  <= 1'b0;
            r_pipe_idx  <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_hit_rank  <= '0;
            r_hit_val   <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_have_old  <= 1'b0;
            r_old_idx   <= '0;
            r_old_rank  <= '0;
            r_old_key   <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end

            r_pipe_vld <= rd_any;
            r_pipe_upd <= i_cmd.upd_rd;
            r_pipe_idx <= r_idx;
            r_strobe   <= i_cmd.reply;

            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (rd_any) begin
                r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            end

            if (i_cmd.load) begin
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
                r_have_old  <= 1'b0;
            end else if (r_pipe_vld && !r_pipe_upd) begin
                // One entry per cycle: first matching key, first free slot, oldest entry.
                if (pipe_valid_entry && (r_rd_key == r_in.key) && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_pipe_idx;
                    r_hit_rank <= r_rd_rank;
                    r_hit_val  <= r_rd_val;
                end
                if (!pipe_valid_entry && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_pipe_idx;
                end
                if (pipe_valid_entry && (!r_have_old || (r_rd_rank > r_old_rank))) begin
                    r_have_old <= 1'b1;
                    r_old_idx  <= r_pipe_idx;
                    r_old_rank <= r_rd_rank;
                    r_old_key  <= r_rd_key;
                end
            end

            if (i_cmd.resolve && sel_fill) begin
                r_valid[slot_sel] <= 1'b1;
                r_count           <= r_count + CNT_W'(1);
            end
        end
    end

    `LKV_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(r_valid) == int'(r_count), "occupancy count out of step with valid bits")
    `LKV_ASSERT_NOW(a_fill_has_free_slot, i_cmd.resolve && sel_fill, r_have_free, "fill chosen without a free slot")
    `LKV_ASSERT_NOW(a_evict_not_hit, r_strobe && r_res.evicted, !r_res.found, "eviction reported on a hit")

endmodule

`default_nettype wire
